[hdl/ttw_pkg.sv]
// Shared constants, command and status types for the text terminal writer.
`timescale 1ns / 1ps

package ttw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);

  localparam int ROW_W   = 5;
  localparam int COL_W   = 7;
  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 8;
  localparam int CELL_W  = CHAR_W + COLOR_W;

  localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0]  SPACE_CODE   = 8'h20;
  localparam logic [CELL_W-1:0]  INIT_CELL    = 16'h0F20;
  localparam logic [COLOR_W-1:0] COLOR_RESET  = 8'd15;

  localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0] COL_LAST  = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0] ROW_RESET = ROW_W'(1);

  localparam logic [ADDR_W-1:0] ADDR_LAST     = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] SCROLL_BASE   = ADDR_W'(COLUMNS);
  localparam logic [ADDR_W-1:0] MOVE_LAST     = ADDR_W'(COLUMNS * (ROWS - 1) - 1);
  localparam logic [ADDR_W-1:0] LAST_ROW_BASE = ADDR_W'(COLUMNS * (ROWS - 1));

  typedef enum logic [1:0] {
    FUNC_PUT    = 2'd0,
    FUNC_READ   = 2'd1,
    FUNC_SETCUR = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_ROW,
    PTR_SCROLL,
    PTR_LAST,
    PTR_INC
  } ptr_sel_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_INIT,
    WR_BLANK,
    WR_PUT,
    WR_MOVE
  } wr_sel_t;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_TARGET,
    RD_SCROLL
  } rd_sel_t;

  typedef enum logic [1:0] {
    CUR_HOLD,
    CUR_PUT,
    CUR_SET
  } cur_op_t;

  typedef struct packed {
    logic     load_item;
    ptr_sel_t ptr_sel;
    wr_sel_t  wr_sel;
    rd_sel_t  rd_sel;
    cur_op_t  cur_op;
    logic     out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    func_t func;
    logic  put_scroll;
    logic  row_ok;
    logic  ptr_last;
    logic  col_last;
    logic  move_last;
  } dp_status_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    return ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
  endfunction

endpackage

[hdl/ttw_datapath.sv]
// Cell store, cursor, colour register, sweep pointer and result registers.
`timescale 1ns / 1ps

module ttw_datapath
  import ttw_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  ctrl_cmd_t          cmd,
  output dp_status_t         status,
  input  logic [1:0]         in_func,
  input  logic [CHAR_W-1:0]  in_char_code,
  input  logic [ROW_W-1:0]   in_target_row,
  input  logic [COL_W-1:0]   in_target_col,
  input  logic               cfg_wr_en,
  input  logic [COLOR_W-1:0] cfg_wr_data,
  output logic [ROW_W-1:0]   out_cursor_row,
  output logic [COL_W-1:0]   out_cursor_col,
  output logic [CELL_W-1:0]  out_cell_value,
  output logic               out_scrolled
);

  logic [CELL_W-1:0]  mem [CELL_COUNT];
  logic [CELL_W-1:0]  rd_data_r;

  func_t              func_r;
  logic [CHAR_W-1:0]  char_r;
  logic [ROW_W-1:0]   trow_r;
  logic [COL_W-1:0]   tcol_r;

  logic [COLOR_W-1:0] color_r;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic               scrolled_r, scrolled_nxt;

  logic [ADDR_W-1:0]  ptr_r, ptr_nxt;
  logic [COL_W-1:0]   cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]  move_addr_r;
  logic               move_pend_r;

  logic [ROW_W-1:0]   out_row_r;
  logic [COL_W-1:0]   out_col_r;
  logic [CELL_W-1:0]  out_cell_r;
  logic               out_scr_r;

  logic               is_newline, wrap, row_ok, tgt_ok;
  logic               wr_en, rd_en;
  logic [ADDR_W-1:0]  wr_addr, rd_addr;
  logic [CELL_W-1:0]  wr_data;

  assign is_newline = (char_r == NEWLINE_CODE);
  assign wrap       = (col_r >= COL_LAST) || is_newline;
  assign row_ok     = (trow_r <= ROW_LAST);
  assign tgt_ok     = row_ok && (tcol_r <= COL_LAST);

  assign status.func       = func_r;
  assign status.put_scroll = wrap && (row_r >= ROW_LAST);
  assign status.row_ok     = row_ok;
  assign status.ptr_last   = (ptr_r == ADDR_LAST);
  assign status.col_last   = (cnt_r == COL_LAST);
  assign status.move_last  = (ptr_r == MOVE_LAST);

  // Sweep pointer and the column count that runs alongside it.
  always_comb begin
    ptr_nxt = ptr_r;
    cnt_nxt = cnt_r;
    case (cmd.ptr_sel)
      PTR_HOLD: begin
      end
      PTR_ROW: begin
        ptr_nxt = cell_addr(trow_r, '0);
        cnt_nxt = '0;
      end
      PTR_SCROLL: begin
        ptr_nxt = SCROLL_BASE;
        cnt_nxt = '0;
      end
      PTR_LAST: begin
        ptr_nxt = LAST_ROW_BASE;
        cnt_nxt = '0;
      end
      PTR_INC: begin
        ptr_nxt = ptr_r + ADDR_W'(1);
        cnt_nxt = cnt_r + COL_W'(1);
      end
      default: begin
      end
    endcase
  end

  // Write port selection.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ptr_r;
    wr_data = {color_r, SPACE_CODE};
    case (cmd.wr_sel)
      WR_NONE: begin
      end
      WR_INIT: begin
        wr_en   = 1'b1;
        wr_data = INIT_CELL;
      end
      WR_BLANK: begin
        wr_en = 1'b1;
      end
      WR_PUT: begin
        wr_en   = !is_newline;
        wr_addr = cell_addr(row_r, col_r);
        wr_data = {color_r, char_r};
      end
      WR_MOVE: begin
        wr_en   = move_pend_r;
        wr_addr = move_addr_r;
        wr_data = rd_data_r;
      end
      default: begin
      end
    endcase
  end

  // Read port selection.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ptr_r + SCROLL_BASE;
    case (cmd.rd_sel)
      RD_NONE: begin
      end
      RD_TARGET: begin
        rd_en   = tgt_ok;
        rd_addr = cell_addr(trow_r, tcol_r);
      end
      RD_SCROLL: begin
        rd_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Cursor update.
  always_comb begin
    row_nxt      = row_r;
    col_nxt      = col_r;
    scrolled_nxt = scrolled_r;
    if (cmd.load_item) begin
      scrolled_nxt = 1'b0;
    end
    case (cmd.cur_op)
      CUR_HOLD: begin
      end
      CUR_PUT: begin
        if (wrap) begin
          col_nxt = '0;
          if (row_r >= ROW_LAST) begin
            row_nxt      = ROW_LAST;
            scrolled_nxt = 1'b1;
          end else begin
            row_nxt = row_r + ROW_W'(1);
          end
        end else begin
          col_nxt = col_r + COL_W'(1);
        end
      end
      CUR_SET: begin
        row_nxt = row_ok ? trow_r : ROW_LAST;
        col_nxt = (tcol_r <= COL_LAST) ? tcol_r : COL_LAST;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_r     <= COLOR_RESET;
      row_r       <= ROW_RESET;
      col_r       <= '0;
      scrolled_r  <= 1'b0;
      ptr_r       <= '0;
      cnt_r       <= '0;
      move_pend_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        color_r <= cfg_wr_data;
      end
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      scrolled_r  <= scrolled_nxt;
      ptr_r       <= ptr_nxt;
      cnt_r       <= cnt_nxt;
      move_pend_r <= (cmd.rd_sel == RD_SCROLL);
    end
  end

  always_ff @(posedge clk) begin
    move_addr_r <= ptr_r;
    if (cmd.load_item) begin
      func_r <= func_t'(in_func);
      char_r <= in_char_code;
      trow_r <= in_target_row;
      tcol_r <= in_target_col;
    end
    if (cmd.out_load) begin
      out_row_r  <= row_r;
      out_col_r  <= col_r;
      out_cell_r <= (func_r == FUNC_READ && tgt_ok) ? rd_data_r : '0;
      out_scr_r  <= scrolled_r;
    end
  end

  assign out_cursor_row = out_row_r;
  assign out_cursor_col = out_col_r;
  assign out_cell_value = out_cell_r;
  assign out_scrolled   = out_scr_r;

endmodule

[hdl/ttw_ctrl.sv]
// Sequencing state machine for the text terminal writer.
`timescale 1ns / 1ps

module ttw_ctrl
  import ttw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DISPATCH,
    ST_CLEAR,
    ST_MOVE,
    ST_DRAIN,
    ST_BLANK,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '{load_item: 1'b0, ptr_sel: PTR_HOLD, wr_sel: WR_NONE,
                      rd_sel: RD_NONE, cur_op: CUR_HOLD, out_load: 1'b0};
    case (state_r)
      ST_INIT: begin
        cmd.wr_sel  = WR_INIT;
        cmd.ptr_sel = PTR_INC;
        if (status.ptr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (status.func)
          FUNC_PUT: begin
            cmd.wr_sel  = WR_PUT;
            cmd.cur_op  = CUR_PUT;
            cmd.ptr_sel = PTR_SCROLL;
            state_nxt   = status.put_scroll ? ST_MOVE : ST_DONE;
          end
          FUNC_READ: begin
            cmd.rd_sel = RD_TARGET;
            state_nxt  = ST_DONE;
          end
          FUNC_SETCUR: begin
            cmd.cur_op = CUR_SET;
            state_nxt  = ST_DONE;
          end
          FUNC_CLEAR: begin
            cmd.ptr_sel = PTR_ROW;
            state_nxt   = status.row_ok ? ST_CLEAR : ST_DONE;
          end
          default: begin
            state_nxt = ST_DONE;
          end
        endcase
      end
      ST_CLEAR: begin
        cmd.wr_sel  = WR_BLANK;
        cmd.ptr_sel = PTR_INC;
        if (status.col_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_MOVE: begin
        cmd.rd_sel  = RD_SCROLL;
        cmd.wr_sel  = WR_MOVE;
        cmd.ptr_sel = PTR_INC;
        if (status.move_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        cmd.wr_sel  = WR_MOVE;
        cmd.ptr_sel = PTR_LAST;
        state_nxt   = ST_BLANK;
      end
      ST_BLANK: begin
        cmd.wr_sel  = WR_BLANK;
        cmd.ptr_sel = PTR_INC;
        if (status.col_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[hdl/text_terminal_writer.sv]
// Top level of the character-cell text terminal writer.
`timescale 1ns / 1ps
// A word is taken in the idle state and worked on in the next cycle; its result is then
// registered in the done state once the result register is free. Clearing a row blanks
// its COLUMNS cells; a scroll moves rows upward and blanks the last row, one cell per
// cycle through the single write port of the cell store. Reset (synchronous, active low)
// starts a pass over all COLUMNS*ROWS cells that fills the store with blank white-on-black
// cells; no word is taken until it ends.

module text_terminal_writer
  import ttw_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_func,
  input  logic [CHAR_W-1:0]  in_char_code,
  input  logic [ROW_W-1:0]   in_target_row,
  input  logic [COL_W-1:0]   in_target_col,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [ROW_W-1:0]   out_cursor_row,
  output logic [COL_W-1:0]   out_cursor_col,
  output logic [CELL_W-1:0]  out_cell_value,
  output logic               out_scrolled,
  input  logic               cfg_wr_en,
  input  logic [COLOR_W-1:0] cfg_wr_data
);

  // The controller steers the datapath through a packed command word each cycle and
  // reads back a small status word (decoded function, end-of-sweep flags, whether the target
  // row is in range and whether the current put runs off the bottom of the screen).
  ctrl_cmd_t  cmd;
  dp_status_t status;

  // The controller owns both handshakes. The result sits in its own register, so a
  // finished result may wait for the consumer while the block returns to idle and
  // takes the next word; only the following result then waits for the register.
  ttw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath holds the cell store (one write and one registered read per cycle),
  // the cursor, the colour register and the result registers. A scroll streams rows
  // upward with the read of one cell overlapping the write of the previous one.
  ttw_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_func        (in_func),
    .in_char_code   (in_char_code),
    .in_target_row  (in_target_row),
    .in_target_col  (in_target_col),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .out_cursor_row (out_cursor_row),
    .out_cursor_col (out_cursor_col),
    .out_cell_value (out_cell_value),
    .out_scrolled   (out_scrolled)
  );

endmodule
